FILE: hdl/bmprle_pkg.sv
// Shared types and constants for the RLE4/RLE8 bitmap stream decoder.
package bmprle_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_DW = 13;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_NIBBLE_MODE  = 2'd2;

    localparam logic [7:0] HI_NIB = 8'hf0;
    localparam logic [7:0] LO_NIB = 8'h0f;

    typedef enum logic [1:0] {
        ST_SPAN      = 2'd0,
        ST_DONE      = 2'd1,
        ST_BAD_LINE  = 2'd2,
        ST_DELTA_OVF = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_CODE   = 7'b0000001,
        PH_ESC    = 7'b0000010,
        PH_RUNVAL = 7'b0000100,
        PH_DX     = 7'b0001000,
        PH_DY     = 7'b0010000,
        PH_LIT    = 7'b0100000,
        PH_PAD    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [CFG_DW-1:0] image_width;
        logic [CFG_DW-1:0] image_height;
        logic              nibble_mode;
    } cfg_t;

    typedef struct packed {
        logic [23:0] start_index;
        logic [19:0] span_count;
        logic [7:0]  value_first;
        logic [7:0]  value_second;
        status_t     status;
        logic        last_of_frame;
    } res_t;

endpackage

FILE: hdl/bmprle_in_reg.sv
// Input register stage: holds one compressed byte until the decoder takes it.
module bmprle_in_reg
    import bmprle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_frame_start
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       fs_reg;
    logic       load;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
            fs_reg   <= frame_start;
        end
    end

    assign item_valid       = valid_reg;
    assign item_byte        = byte_reg;
    assign item_frame_start = fs_reg;

endmodule

FILE: hdl/bmprle_decode.sv
// Parse state machine, position tracking and span computation for one byte.
module bmprle_decode
    import bmprle_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NW = (CW > 8) ? CW : 8;
    localparam int SW = ((HW > 8) ? HW : 8) + 1;
    localparam int PW = RW + CW;
    localparam int DW = CW + 8;

    phase_t        phase_reg, phase_next, cur_phase;
    logic [RW-1:0] row_reg, row_next, cur_row;
    logic [CW-1:0] col_reg, col_next, cur_col;
    logic [7:0]    pend_reg, pend_next, cur_pend;
    logic          pad_reg, pad_next, cur_pad;
    logic [7:0]    dx_reg, dx_next, cur_dx;
    logic          stop_reg, stop_next, cur_stop;

    logic [CW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          full;
    logic [CW-1:0] room;
    logic [7:0]    lit_pix;
    logic [7:0]    want;
    logic [NW-1:0] span_n;
    logic [NW-1:0] dxc;
    logic [PW-1:0] row_base;
    logic [PW:0]   base_idx;
    logic [DW-1:0] dy_area;
    logic [SW-1:0] row_p1;
    logic [SW-1:0] dy_end;
    logic [7:0]    val_a;
    logic [7:0]    val_b;
    logic [8:0]    lit_plus1;

    // Register values used as-is by the decoder are clamped into range.
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            eff_w = CW'(1);
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW'(cfg.image_width);
        end
        if (cfg.image_height == '0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(cfg.image_height) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(cfg.image_height);
        end
    end

    // frame_start restarts decoding before this byte is parsed
    always_comb
    begin
        if (frame_start)
        begin
            cur_phase = PH_CODE;
            cur_row   = '0;
            cur_col   = '0;
            cur_pend  = '0;
            cur_pad   = 1'b0;
            cur_dx    = '0;
            cur_stop  = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_row   = row_reg;
            cur_col   = col_reg;
            cur_pend  = pend_reg;
            cur_pad   = pad_reg;
            cur_dx    = dx_reg;
            cur_stop  = stop_reg;
        end
    end

    always_comb
    begin
        full     = cur_col >= eff_w;
        room     = full ? '0 : (eff_w - cur_col);
        lit_pix  = (cfg.nibble_mode && (cur_pend >= 8'd2)) ? 8'd2 : 8'd1;
        want     = (cur_phase == PH_RUNVAL) ? cur_pend : lit_pix;
        span_n   = (NW'(want) < NW'(room)) ? NW'(want) : NW'(room);
        dxc      = (NW'(cur_dx) < NW'(room)) ? NW'(cur_dx) : NW'(room);
        row_base = PW'(cur_row) * PW'(eff_w);
        base_idx = (PW+1)'(row_base) + (PW+1)'(cur_col);
        dy_area  = DW'(data_byte) * DW'(eff_w);
        row_p1   = SW'(cur_row) + SW'(1);
        dy_end   = row_p1 + SW'(data_byte);
        lit_plus1 = 9'(data_byte) + 9'd1;
        if (cfg.nibble_mode)
        begin
            val_a = (data_byte & HI_NIB) >> 4;
            val_b = data_byte & LO_NIB;
        end
        else
        begin
            val_a = data_byte;
            val_b = data_byte;
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        row_next   = cur_row;
        col_next   = cur_col;
        pend_next  = cur_pend;
        pad_next   = cur_pad;
        dx_next    = cur_dx;
        stop_next  = cur_stop;
        res_valid  = 1'b0;
        res        = '0;

        if (!cur_stop)
        begin
            case (cur_phase)
                PH_CODE:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (full)
                    begin
                        stop_next         = 1'b1;
                        phase_next        = PH_CODE;
                        res_valid         = 1'b1;
                        res.status        = ST_BAD_LINE;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        pend_next  = data_byte;
                        phase_next = PH_RUNVAL;
                    end
                end
                PH_RUNVAL, PH_LIT:
                begin
                    if (cur_phase == PH_RUNVAL)
                    begin
                        phase_next = PH_CODE;
                    end
                    else
                    begin
                        pend_next = (cur_pend >= lit_pix) ? (cur_pend - lit_pix) : '0;
                        if (pend_next == '0)
                        begin
                            phase_next = cur_pad ? PH_PAD : PH_CODE;
                        end
                    end
                    if (span_n != '0)
                    begin
                        col_next         = cur_col + CW'(span_n);
                        res_valid        = 1'b1;
                        res.start_index  = 24'(base_idx);
                        res.span_count   = 20'(span_n);
                        res.value_first  = val_a;
                        res.value_second = val_b;
                        res.status       = ST_SPAN;
                    end
                end
                PH_ESC:
                begin
                    if (full)
                    begin
                        if (data_byte == 8'd1 || (data_byte == 8'd0 && row_p1 >= SW'(eff_h)))
                        begin
                            stop_next         = 1'b1;
                            phase_next        = PH_CODE;
                            res_valid         = 1'b1;
                            res.status        = ST_DONE;
                            res.last_of_frame = 1'b1;
                        end
                        else if (data_byte != 8'd0)
                        begin
                            stop_next         = 1'b1;
                            phase_next        = PH_CODE;
                            res_valid         = 1'b1;
                            res.status        = ST_BAD_LINE;
                            res.last_of_frame = 1'b1;
                        end
                        else
                        begin
                            row_next   = cur_row + RW'(1);
                            col_next   = '0;
                            phase_next = PH_CODE;
                        end
                    end
                    else if (data_byte <= 8'd1)
                    begin
                        // end of line or image before the row is full
                        stop_next         = 1'b1;
                        phase_next        = PH_CODE;
                        res_valid         = 1'b1;
                        res.status        = ST_BAD_LINE;
                        res.last_of_frame = 1'b1;
                    end
                    else if (data_byte == 8'd2)
                    begin
                        phase_next = PH_DX;
                    end
                    else
                    begin
                        pend_next  = data_byte;
                        // pad when the literal occupies an odd number of source bytes
                        pad_next   = cfg.nibble_mode ? lit_plus1[1] : data_byte[0];
                        phase_next = PH_LIT;
                    end
                end
                PH_DX:
                begin
                    dx_next    = data_byte;
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    if (dy_end > SW'(eff_h))
                    begin
                        stop_next         = 1'b1;
                        phase_next        = PH_CODE;
                        res_valid         = 1'b1;
                        res.status        = ST_DELTA_OVF;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        col_next   = cur_col + CW'(dxc);
                        row_next   = cur_row + RW'(data_byte);
                        phase_next = PH_CODE;
                        if (dxc != '0 || data_byte != 8'd0)
                        begin
                            res_valid       = 1'b1;
                            res.start_index = 24'(base_idx);
                            res.span_count  = 20'((DW+1)'(dy_area) + (DW+1)'(dxc));
                            res.status      = ST_SPAN;
                        end
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_CODE;
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            row_reg   <= '0;
            col_reg   <= '0;
            pend_reg  <= '0;
            pad_reg   <= 1'b0;
            dx_reg    <= '0;
            stop_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pend_reg  <= pend_next;
            pad_reg   <= pad_next;
            dx_reg    <= dx_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

FILE: hdl/bmprle_out_reg.sv
// Result register: holds one span or status transaction until taken.
module bmprle_out_reg
    import bmprle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        res_valid,
    input  res_t        res,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] start_index,
    output logic [19:0] span_count,
    output logic [7:0]  value_first,
    output logic [7:0]  value_second,
    output logic [1:0]  status,
    output logic        last_of_frame
);

    logic valid_reg;
    res_t res_reg;

    // a new result may enter when the slot is empty or drains this cycle
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign start_index   = res_reg.start_index;
    assign span_count    = res_reg.span_count;
    assign value_first   = res_reg.value_first;
    assign value_second  = res_reg.value_second;
    assign status        = res_reg.status;
    assign last_of_frame = res_reg.last_of_frame;

endmodule

FILE: hdl/bmp_rle4_rle8_decoder.sv
// Top level of the RLE4/RLE8 bitmap stream decoder with configuration registers.
//
//   channel   signals                                   dir   width
//   input     in_valid / in_stall, data_byte,           in    8 + 1
//             frame_start
//   output    out_valid / out_stall, start_index,       out   24+20+8+8+2+1
//             span_count, value_first, value_second,
//             status, last_of_frame
//   config    cfg_write, cfg_index, cfg_data            in    2 + 13
//
// One byte per cycle sustained while out_stall is low; an accepted byte waits in the input
// register, then is decoded into the result register (out_stall can hold it in between).
// The throughput bound is the single decode pass per byte, which holds the
// row-times-width multiply and the row-end clip.
// Reset clears the parse state and sets width and height to 1, RLE8 mode.
// out_stall holds the result register; in_stall rises only while both the
// input register and the result register are occupied.
module bmp_rle4_rle8_decoder
    import bmprle_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [23:0]       start_index,
    output logic [19:0]       span_count,
    output logic [7:0]        value_first,
    output logic [7:0]        value_second,
    output logic [1:0]        status,
    output logic              last_of_frame,
    input  logic              cfg_write,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       advance;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_fs;
    logic       fire;
    logic       res_valid;
    res_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= CFG_DW'(1);
            cfg_reg.image_height <= CFG_DW'(1);
            cfg_reg.nibble_mode  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_NIBBLE_MODE:  cfg_reg.nibble_mode  <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign fire = item_valid && advance;

    bmprle_in_reg u_in_reg (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .frame_start      (frame_start),
        .advance          (advance),
        .item_valid       (item_valid),
        .item_byte        (item_byte),
        .item_frame_start (item_fs)
    );

    bmprle_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (item_byte),
        .frame_start (item_fs),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    bmprle_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .res_valid     (res_valid),
        .res           (res),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_index   (start_index),
        .span_count    (span_count),
        .value_first   (value_first),
        .value_second  (value_second),
        .status        (status),
        .last_of_frame (last_of_frame)
    );

endmodule
